>>> hdl/lbeu_pkg.sv
// Shared types and constants for the LED blink and button event unit.
package lbeu_pkg;

  typedef enum logic [1:0] {
    KIND_POLL  = 2'd0,
    KIND_LED   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    LED_ON   = 2'd0,
    LED_OFF  = 2'd1,
    LED_FAST = 2'd2,
    LED_SLOW = 2'd3
  } led_op_e;

  localparam int unsigned CntW = 7;

  localparam logic [CntW-1:0] FastOffAt  = 7'd13;
  localparam logic [CntW-1:0] FastPeriod = 7'd25;
  localparam logic [CntW-1:0] SlowOffAt  = 7'd50;
  localparam logic [CntW-1:0] SlowPeriod = 7'd100;

  localparam int unsigned EvResume = 0;
  localparam int unsigned EvHome   = 1;
  localparam int unsigned EvEmerg  = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic       tick;
    logic       btn_resume;
    logic       btn_home;
    logic       btn_emerg;
    logic [1:0] led_index;
    logic [1:0] led_op;
    logic [2:0] clear_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0] led_levels;
    logic       ev_resume;
    logic       ev_toolchange;
    logic       ev_emerg;
  } out_item_t;

  // Per-LED control for one processed request.
  typedef struct packed {
    logic    step;
    logic    cmd;
    led_op_e op;
  } led_ctrl_t;

  // Button and event control for one processed request.
  typedef struct packed {
    logic       poll;
    logic       clear;
    logic       tick;
    logic       resume;
    logic       home;
    logic       emerg;
    logic [2:0] clear_mask;
  } btn_ctrl_t;

endpackage

>>> hdl/lbeu_led_cell.sv
// One LED: its mode, blink counter and level.
module lbeu_led_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbeu_pkg::led_ctrl_t ctrl_i,
  output logic               level_d_o
);
  import lbeu_pkg::*;

  led_op_e         mode_q, mode_d;
  logic [CntW-1:0] count_q, count_d;
  logic            level_q, level_d;
  logic [CntW-1:0] off_at, period, count_inc;

  always_comb begin
    off_at    = (mode_q == LED_SLOW) ? SlowOffAt : FastOffAt;
    period    = (mode_q == LED_SLOW) ? SlowPeriod : FastPeriod;
    count_inc = count_q + CntW'(1);
  end

  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    level_d = level_q;
    if (ctrl_i.step && (mode_q == LED_FAST || mode_q == LED_SLOW)) begin
      // The level follows the count before it advances.
      if (count_q == '0) begin
        level_d = 1'b1;
      end else if (count_q == off_at) begin
        level_d = 1'b0;
      end
      count_d = (count_inc == period) ? '0 : count_inc;
    end
    if (ctrl_i.cmd) begin
      case (ctrl_i.op)
        LED_ON:  level_d = 1'b1;
        LED_OFF: level_d = 1'b0;
        default: begin
          if (mode_q != ctrl_i.op) begin
            count_d = '0;
          end
        end
      endcase
      mode_d = ctrl_i.op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= LED_ON;
      count_q <= '0;
      level_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      count_q <= count_d;
      level_q <= level_d;
    end
  end

  assign level_d_o = level_d;

endmodule

>>> hdl/lbeu_buttons.sv
// Button sampling prescaler, edge detection and sticky event flags.
module lbeu_buttons #(
  parameter int unsigned SAMPLE_DIV = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                emerg_en_i,
  input  lbeu_pkg::btn_ctrl_t ctrl_i,
  output logic [2:0]          events_q_o,
  output logic [2:0]          events_d_o
);
  import lbeu_pkg::*;

  localparam int unsigned DivW = (SAMPLE_DIV < 2) ? 1 : $clog2(SAMPLE_DIV + 1);

  logic [DivW-1:0] div_q, div_d, div_base, div_inc;
  logic [2:0]      prev_q, prev_d;
  logic [2:0]      events_q, events_d;

  always_comb begin
    div_d    = div_q;
    prev_d   = prev_q;
    events_d = events_q;
    div_base = div_q;
    if (ctrl_i.poll && emerg_en_i && ctrl_i.emerg) begin
      events_d[EvEmerg] = 1'b1;
      prev_d[EvEmerg]   = 1'b1;
      div_base          = '0;
    end
    div_inc = div_base + DivW'(1);
    if (ctrl_i.poll) begin
      div_d = div_base;
      if (ctrl_i.tick) begin
        if (div_inc < DivW'(SAMPLE_DIV)) begin
          div_d = div_inc;
        end else begin
          div_d = '0;
          // A press seen on a sample after a release raises the event.
          events_d[EvResume] = events_d[EvResume] | (ctrl_i.resume & ~prev_d[EvResume]);
          events_d[EvHome]   = events_d[EvHome] | (ctrl_i.home & ~prev_d[EvHome]);
          prev_d[EvResume]   = ctrl_i.resume;
          prev_d[EvHome]     = ctrl_i.home;
          prev_d[EvEmerg]    = prev_d[EvEmerg] & ctrl_i.emerg;
        end
      end
    end
    if (ctrl_i.clear) begin
      events_d = events_q & ~ctrl_i.clear_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q    <= '0;
      prev_q   <= '0;
      events_q <= '0;
    end else begin
      div_q    <= div_d;
      prev_q   <= prev_d;
      events_q <= events_d;
    end
  end

  assign events_q_o = events_q;
  assign events_d_o = events_d;

endmodule

>>> hdl/led_blink_and_button_event_unit_core.sv
// LED blink and button event unit: request and result stages around the LED and button logic.
//
// Input channel in_valid_i/in_ready_o carries one request: a poll (tick flag and button
// levels), an LED command (index and operation) or an event clear (mask). Every request
// gives exactly one result on out_valid_o/out_ready_i showing the three LED levels and
// the sticky resume, toolchange and emergency events after that request.
// The configuration bit emerg_enable is written with cfg_we_i/cfg_wdata_i.
//
// A request is taken into an input register, processed from that register by the
// compare-and-count logic of the LED cells and the button unit, and its result is held
// in the output register: out_valid_o rises at the clock edge that stores the result.
// One request is taken every cycle while the receiver keeps up.
// When the receiver stalls, the result stays in the output register and one further
// request may still be taken into the input register; only then does in_ready_o fall.
// Reset clears both stages, all LED modes to steady on with levels off, the counters,
// the button history, the events and emerg_enable.
module led_blink_and_button_event_unit_core #(
  parameter int unsigned NUM_LEDS   = 3,
  parameter int unsigned SAMPLE_DIV = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lbeu_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lbeu_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);
  import lbeu_pkg::*;

  logic          in_valid_q;
  in_item_t      in_q;
  logic          out_valid_q;
  out_item_t     out_q, out_d;
  logic          emerg_en_q;
  logic          fire;
  kind_e         kind;
  btn_ctrl_t     btn_ctrl;
  logic [2:0]    events_q, events_d;
  logic [NUM_LEDS-1:0] level_d;
  logic [2:0]    levels;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign kind       = kind_e'(in_q.kind);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      emerg_en_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        emerg_en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    btn_ctrl.poll       = fire && (kind == KIND_POLL);
    btn_ctrl.clear      = fire && (kind == KIND_CLEAR);
    btn_ctrl.tick       = in_q.tick;
    btn_ctrl.resume     = in_q.btn_resume;
    btn_ctrl.home       = in_q.btn_home;
    btn_ctrl.emerg      = in_q.btn_emerg;
    btn_ctrl.clear_mask = in_q.clear_mask;
  end

  lbeu_buttons #(
    .SAMPLE_DIV(SAMPLE_DIV)
  ) u_buttons (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .emerg_en_i(emerg_en_q),
    .ctrl_i    (btn_ctrl),
    .events_q_o(events_q),
    .events_d_o(events_d)
  );

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
    led_ctrl_t ctrl;
    always_comb begin
      ctrl.step = fire && (kind == KIND_POLL) && in_q.tick;
      // An index beyond the fitted LEDs matches no cell and is ignored.
      ctrl.cmd  = fire && (kind == KIND_LED) && (32'(in_q.led_index) == i);
      ctrl.op   = led_op_e'(in_q.led_op);
    end
    lbeu_led_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .level_d_o(level_d[i])
    );
  end

  for (genvar j = 0; j < 3; j++) begin : g_level
    if (j < NUM_LEDS) begin : g_fitted
      assign levels[j] = level_d[j];
    end else begin : g_absent
      assign levels[j] = 1'b0;
    end
  end

  always_comb begin
    out_d.led_levels    = levels;
    out_d.ev_resume     = events_d[EvResume];
    out_d.ev_toolchange = events_d[EvHome];
    out_d.ev_emerg      = events_d[EvEmerg];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The input stage only holds back when a result is waiting on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled without a pending result");

  // Every processed request produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed request produced no result");

  // Sticky events only drop through a clear request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((events_q & ~$past(events_q)) == 3'b000 && events_q != $past(events_q)) |->
      $past(fire && (kind == KIND_CLEAR)))
    else $error("sticky event dropped without a clear");

endmodule
